FILE: rtl/core/sm4_pkg.sv
// Shared types, constants and round functions for the SM4 encryption pipeline.
`timescale 1ns / 1ps

package sm4_pkg;

  // Number of rounds of the cipher.
  localparam int unsigned ROUND_COUNT = 32;

  // Configuration port layout.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] KEY_WORD_0_IDX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD_1_IDX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD_2_IDX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD_3_IDX = 2'd3;

  // System parameter FK, word 0 in the lowest slot.
  localparam logic [3:0][31:0] FK = {32'hB27022DC, 32'h677D9197, 32'h56AA3350, 32'hA3B1BAC6};

  // Payload that moves down the pipeline: the four data words and the sliding
  // window of key schedule words. The newest key word k[3] is the round key
  // that the next round consumes.
  typedef struct packed {
    logic [3:0][31:0] x;
    logic [3:0][31:0] k;
  } sm4_data_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  // Rotate left; the amount is always a constant at the call site.
  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Byte-wise S-box substitution of a word.
  function automatic logic [31:0] sm4_tau(input logic [31:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // Data path transform: substitution followed by the linear map L.
  function automatic logic [31:0] sm4_t_enc(input logic [31:0] v);
    logic [31:0] b;
    b = sm4_tau(v);
    return b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
  endfunction

  // Key schedule transform: substitution followed by the linear map L'.
  function automatic logic [31:0] sm4_t_key(input logic [31:0] v);
    logic [31:0] b;
    b = sm4_tau(v);
    return b ^ rotl32(b, 13) ^ rotl32(b, 23);
  endfunction

  // Constant CK for round i: byte j is (4*i + j) * 7 modulo 256.
  function automatic logic [31:0] ck_word(input int unsigned i);
    logic [31:0] r;
    r = '0;
    for (int unsigned j = 0; j < 4; j++) begin
      r = {r[23:0], 8'(((4 * i) + j) * 7)};
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/sm4_round.sv
// One pipeline stage of SM4: a cipher round and the next key schedule step.
`timescale 1ns / 1ps

module sm4_round #(
  parameter int unsigned Round = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  sm4_pkg::sm4_data_t data_i,
  output logic              valid_o,
  output sm4_pkg::sm4_data_t data_o
);
  import sm4_pkg::*;

  // The key word made here is the round key for the following stage.
  localparam logic [31:0] CkNext = ck_word(Round + 1);

  logic       valid_q;
  sm4_data_t  data_d;
  sm4_data_t  data_q;
  logic [31:0] x_new;
  logic [31:0] k_new;

  always_comb begin
    x_new = data_i.x[0] ^ sm4_t_enc(data_i.x[1] ^ data_i.x[2] ^ data_i.x[3] ^ data_i.k[3]);
    k_new = data_i.k[0] ^ sm4_t_key(data_i.k[1] ^ data_i.k[2] ^ data_i.k[3] ^ CkNext);
    data_d.x = {x_new, data_i.x[3], data_i.x[2], data_i.x[1]};
    data_d.k = {k_new, data_i.k[3], data_i.k[2], data_i.k[1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/core/sm4_block_encrypt.sv
// Top level of the pipelined SM4 block encryption engine.
`timescale 1ns / 1ps

// Channel   | Direction | Ports                                  | Transfer
// ----------+-----------+----------------------------------------+---------------------------
// request   | in        | start_i, busy_o, plain_word_0..3_i     | start_i high, busy_o low
// result    | out       | done_o, cipher_word_0..3_o             | done_o high for one cycle
// config    | in        | cfg_we_i, cfg_idx_i, cfg_wdata_i       | cfg_we_i high
//
// A request is taken in every cycle; busy_o stays low. Each request passes
// through one entry stage that loads the block and makes the first round key,
// then through one stage per round, whose last register holds its result.
// Reset clears the key registers and every valid bit of the pipeline.
// The result side cannot be stalled, so the pipeline never holds.
module sm4_block_encrypt #(
  parameter int unsigned RoundCount = sm4_pkg::ROUND_COUNT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request channel.
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [31:0]                    plain_word_0_i,
  input  logic [31:0]                    plain_word_1_i,
  input  logic [31:0]                    plain_word_2_i,
  input  logic [31:0]                    plain_word_3_i,
  // Result channel.
  output logic                           done_o,
  output logic [31:0]                    cipher_word_0_o,
  output logic [31:0]                    cipher_word_1_o,
  output logic [31:0]                    cipher_word_2_o,
  output logic [31:0]                    cipher_word_3_o,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [sm4_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sm4_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import sm4_pkg::*;

  logic [3:0][31:0] key_q;
  logic [3:0][31:0] key_d;
  logic [3:0][31:0] kk;
  logic             accept;
  sm4_data_t        entry_d;
  logic             entry_valid_q;
  sm4_data_t        entry_data_q;

  // Stage 0 is the entry register; stage r + 1 is the output of round r.
  logic      valid_s [RoundCount+1];
  sm4_data_t data_s  [RoundCount+1];

  // The engine never refuses a request.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Key registers. The user must write them only while no request is in flight;
  // the block does not enforce it. Then every request in the pipeline sees the same key.
  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        KEY_WORD_0_IDX: key_d[0] = cfg_wdata_i;
        KEY_WORD_1_IDX: key_d[1] = cfg_wdata_i;
        KEY_WORD_2_IDX: key_d[2] = cfg_wdata_i;
        KEY_WORD_3_IDX: key_d[3] = cfg_wdata_i;
        default:        key_d    = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  // Entry stage: load the block and start the key schedule. The key window
  // carries K1..K3 and the first round key, so each round stage can derive the
  // next round key in parallel with its own cipher round.
  always_comb begin
    kk = key_q ^ FK;
    entry_d.x = {plain_word_3_i, plain_word_2_i, plain_word_1_i, plain_word_0_i};
    entry_d.k = {kk[0] ^ sm4_t_key(kk[1] ^ kk[2] ^ kk[3] ^ ck_word(0)), kk[3], kk[2], kk[1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else begin
      entry_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_data_q <= entry_d;
    end
  end

  assign valid_s[0] = entry_valid_q;
  assign data_s[0]  = entry_data_q;

  // One registered stage per round.
  for (genvar g = 0; g < RoundCount; g++) begin : g_round
    sm4_round #(
      .Round (g)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[g]),
      .data_i  (data_s[g]),
      .valid_o (valid_s[g+1]),
      .data_o  (data_s[g+1])
    );
  end

  // The last round's register is the output register; the final word order is
  // reversed.
  assign done_o          = valid_s[RoundCount];
  assign cipher_word_0_o = data_s[RoundCount].x[3];
  assign cipher_word_1_o = data_s[RoundCount].x[2];
  assign cipher_word_2_o = data_s[RoundCount].x[1];
  assign cipher_word_3_o = data_s[RoundCount].x[0];

endmodule

FILE: rtl/core/sm4_checker.sv
// Port-level checks of the SM4 encryption engine and their attachment to it.
`timescale 1ns / 1ps

module sm4_checker #(
  parameter int unsigned RoundCount = sm4_pkg::ROUND_COUNT
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);
  import sm4_pkg::*;

  localparam int unsigned Latency = RoundCount + 1;
  localparam int unsigned CntW    = $clog2(Latency + 2);

  // Cycles since reset was released, saturating once the pipeline has filled.
  logic [CntW-1:0] up_cnt_q;
  logic [CntW-1:0] up_cnt_d;
  logic            filled;

  assign filled   = (up_cnt_q > CntW'(Latency));
  assign up_cnt_d = filled ? up_cnt_q : up_cnt_q + CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_cnt_q <= '0;
    end else begin
      up_cnt_q <= up_cnt_d;
    end
  end

  // Full rate: a request is never refused.
  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("engine refused a request");

  // Every taken request gives exactly one result after the fixed latency.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled |-> (done_o == $past(start_i && !busy_o, Latency)))
    else $error("result strobe does not match a request taken earlier");

  // No result can appear before the first request has had time to pass through.
  a_no_early_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !filled |-> (!done_o || (up_cnt_q >= CntW'(Latency))))
    else $error("result appeared before any request could complete");

endmodule

bind sm4_block_encrypt sm4_checker #(
  .RoundCount (RoundCount)
) u_sm4_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);

FILE: test/tb_sm4_block_encrypt.sv
// Testbench for the SM4 encryption engine: randomized requests checked against a local cipher model.
`timescale 1ns / 1ps

module tb_sm4_block_encrypt;

  // One 128-bit block as four words; word 0 is the first, least significant word.
  typedef logic [3:0][31:0] block_t;

  localparam int ROUNDS          = 32;
  localparam int SETTLE_CYCLES   = ROUNDS + 8;
  localparam int RANDOM_PHASES   = 8;
  localparam int BLOCKS_PER_PHASE = 229;

  // Register indexes in key word order, so that loops can address them.
  localparam logic [sm4_pkg::CFG_IDX_W-1:0] KEY_IDX [4] = '{
    sm4_pkg::KEY_WORD_0_IDX, sm4_pkg::KEY_WORD_1_IDX,
    sm4_pkg::KEY_WORD_2_IDX, sm4_pkg::KEY_WORD_3_IDX
  };

  // System parameter of the key schedule, first word first.
  localparam logic [31:0] KEY_WHITEN [4] = '{
    32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
  };

  // Byte substitution table of the cipher.
  localparam logic [7:0] SUBST_TABLE [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  // Every input starts at a known value; the driver and the sequence take over after reset.
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start_i        = 1'b0;
  logic [31:0] plain_word_0_i = '0;
  logic [31:0] plain_word_1_i = '0;
  logic [31:0] plain_word_2_i = '0;
  logic [31:0] plain_word_3_i = '0;
  logic        cfg_we_i       = 1'b0;
  logic [sm4_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [sm4_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  logic        busy_o;
  logic        done_o;
  logic [31:0] cipher_word_0_o;
  logic [31:0] cipher_word_1_o;
  logic [31:0] cipher_word_2_o;
  logic [31:0] cipher_word_3_o;

  // Plaintext blocks waiting to be sent, and ciphertexts owed by the engine in request order.
  block_t plaintext_q [$];
  block_t ciphertext_q [$];

  // Local copy of the key registers and the round keys derived from them.
  logic [31:0] key_copy   [4] = '{default: '0};
  logic [31:0] round_keys [ROUNDS];

  int failures   = 0;
  int burst_left = 1;
  int gap_left   = 0;

  sm4_block_encrypt u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .plain_word_0_i (plain_word_0_i),
    .plain_word_1_i (plain_word_1_i),
    .plain_word_2_i (plain_word_2_i),
    .plain_word_3_i (plain_word_3_i),
    .done_o         (done_o),
    .cipher_word_0_o(cipher_word_0_o),
    .cipher_word_1_o(cipher_word_1_o),
    .cipher_word_2_o(cipher_word_2_o),
    .cipher_word_3_o(cipher_word_3_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Cipher model
  // ---------------------------------------------------------------------------

  // Rotate left: the upper half of the doubled word shifted by n.
  function automatic logic [31:0] rol(input logic [31:0] w, input int n);
    logic [63:0] doubled;
    doubled = {w, w} << n;
    return doubled[63:32];
  endfunction

  function automatic logic [31:0] substitute(input logic [31:0] w);
    logic [31:0] s;
    for (int b = 0; b < 4; b++) begin
      s[8*b +: 8] = SUBST_TABLE[w[8*b +: 8]];
    end
    return s;
  endfunction

  // Linear diffusion of the data rounds.
  function automatic logic [31:0] data_mix(input logic [31:0] w);
    return w ^ rol(w, 2) ^ rol(w, 10) ^ rol(w, 18) ^ rol(w, 24);
  endfunction

  // Lighter diffusion used by the key schedule.
  function automatic logic [31:0] key_mix(input logic [31:0] w);
    return w ^ rol(w, 13) ^ rol(w, 23);
  endfunction

  // Round constant: byte j of word r, counted from the top, is 7 * (4r + j) mod 256.
  function automatic logic [31:0] round_constant(input int r);
    logic [31:0] c;
    for (int j = 0; j < 4; j++) begin
      c[31 - 8*j -: 8] = 8'((4*r + j) * 7);
    end
    return c;
  endfunction

  // Rebuilds the round keys from the current key registers.
  function automatic void derive_round_keys();
    logic [31:0] k [4];
    logic [31:0] fresh;
    for (int i = 0; i < 4; i++) begin
      k[i] = key_copy[i] ^ KEY_WHITEN[i];
    end
    for (int r = 0; r < ROUNDS; r++) begin
      fresh = k[0] ^ key_mix(substitute(k[1] ^ k[2] ^ k[3] ^ round_constant(r)));
      round_keys[r] = fresh;
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = fresh;
    end
  endfunction

  // Thirty-two rounds over a sliding window of four words, then the window reversed.
  function automatic block_t encrypt_block(input block_t plain);
    logic [31:0] x [4];
    logic [31:0] fresh;
    block_t      cipher;
    for (int i = 0; i < 4; i++) begin
      x[i] = plain[i];
    end
    for (int r = 0; r < ROUNDS; r++) begin
      fresh = x[0] ^ data_mix(substitute(x[1] ^ x[2] ^ x[3] ^ round_keys[r]));
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = fresh;
    end
    for (int i = 0; i < 4; i++) begin
      cipher[i] = x[3 - i];
    end
    return cipher;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Sends queued blocks in bursts of random length. About one burst in four is a
  // long run with no gap before it, so the pipeline also sees back-to-back traffic.
  // A request that is not taken stays on the ports unchanged.
  always @(posedge clk_i) begin : drive_requests
    block_t next_block;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!(start_i && busy_o)) begin
      if (gap_left != 0 || plaintext_q.size() == 0) begin
        start_i <= 1'b0;
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end
      end else begin
        next_block = plaintext_q.pop_front();
        start_i        <= 1'b1;
        plain_word_0_i <= next_block[0];
        plain_word_1_i <= next_block[1];
        plain_word_2_i <= next_block[2];
        plain_word_3_i <= next_block[3];
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
          gap_left   <= 0;
          burst_left <= $urandom_range(30, 150);
        end else begin
          gap_left   <= $urandom_range(1, 37);
          burst_left <= $urandom_range(1, 12);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and checker
  // ---------------------------------------------------------------------------

  // Records the ciphertext owed for every request taken, then checks any result
  // on the ports against the oldest one owed. Recording first keeps the outcome
  // independent of the order of the two channels within one edge.
  always @(posedge clk_i) begin : check_results
    block_t seen;
    block_t owed;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        ciphertext_q.push_back(encrypt_block(
          {plain_word_3_i, plain_word_2_i, plain_word_1_i, plain_word_0_i}));
      end
      if (done_o) begin
        seen = {cipher_word_3_o, cipher_word_2_o, cipher_word_1_o, cipher_word_0_o};
        if (ciphertext_q.size() == 0) begin
          if (failures < 10) begin
            $display("%0t: result %08h %08h %08h %08h with no request outstanding",
                     $realtime, seen[0], seen[1], seen[2], seen[3]);
          end
          failures++;
        end else begin
          owed = ciphertext_q.pop_front();
          if (seen != owed) begin
            if (failures < 10) begin
              for (int i = 0; i < 4; i++) begin
                if (seen[i] != owed[i]) begin
                  $display("%0t: cipher_word_%0d expected %08h, got %08h",
                           $realtime, i, owed[i], seen[i]);
                end
              end
            end
            failures++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  // Word with a bias toward the corners: zero, all ones, a lone set or clear bit.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_block(input logic [31:0] w0, input logic [31:0] w1,
                             input logic [31:0] w2, input logic [31:0] w3);
    plaintext_q.push_back({w3, w2, w1, w0});
  endtask

  // Waits until every queued request has gone out and every result has come back.
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (plaintext_q.size() != 0 || start_i || ciphertext_q.size() != 0);
  endtask

  // Writes the key words selected by the mask on consecutive cycles. Only called
  // while the engine is idle, so the model may take the new key right away.
  task automatic load_key(input logic [3:0] mask, input logic [31:0] w0,
                          input logic [31:0] w1, input logic [31:0] w2,
                          input logic [31:0] w3);
    logic [31:0] words [4];
    words = '{w0, w1, w2, w3};
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        @(posedge clk_i);
        cfg_we_i    <= 1'b1;
        cfg_idx_i   <= KEY_IDX[i];
        cfg_wdata_i <= words[i];
        key_copy[i] = words[i];
      end
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    derive_round_keys();
  endtask

  initial begin : run_sequence
    logic [3:0] mask;
    derive_round_keys();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The key is still all zero from reset: corner plaintexts first.
    queue_block('0, '0, '0, '0);
    queue_block('1, '1, '1, '1);
    queue_block(32'h8000_0000, 32'h0, 32'h0, 32'h0000_0001);
    queue_block(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_block(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
    queue_block(32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    wait_idle();

    // The published example key, with its own plaintext among a few others.
    load_key(4'b1111, 32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
    queue_block(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
    queue_block('0, '0, '0, '0);
    queue_block('1, '1, '1, '1);
    queue_block(32'hDEAD_BEEF, 32'h0000_0001, 32'h8000_0000, 32'hCAFE_F00D);
    wait_idle();

    // Key of all ones.
    load_key(4'b1111, '1, '1, '1, '1);
    queue_block('0, '0, '0, '0);
    queue_block('1, '1, '1, '1);
    queue_block(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
    wait_idle();

    // A change of a single key word has to reach the very next block.
    load_key(4'b0100, '0, '0, 32'h8000_0001, '0);
    queue_block('0, '0, '0, '0);
    queue_block(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
    wait_idle();

    // Random phases. The first rewrites the whole key, the second clears it again,
    // the rest change a random subset of the words.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 1) begin
        load_key(4'b1111, '0, '0, '0, '0);
      end else begin
        mask = (p == 0) ? 4'b1111 : 4'($urandom_range(1, 15));
        load_key(mask, pick_word(), pick_word(), pick_word(), pick_word());
      end
      for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
        queue_block(pick_word(), pick_word(), pick_word(), pick_word());
      end
      wait_idle();
    end

    // Let the pipeline run dry so that a stray extra result would still be seen.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (ciphertext_q.size() != 0) begin
      $display("%0d results never arrived", ciphertext_q.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // The watchdog limit lies well beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sm4_pkg.sv
rtl/core/sm4_round.sv
rtl/core/sm4_block_encrypt.sv
rtl/core/sm4_checker.sv
test/tb_sm4_block_encrypt.sv
